### sv/rbd_pkg.sv
// rbd_pkg: shared types and constants of the retry backoff decision block
// no dependencies; used by retry_backoff_decision_core and rbd_checker
package rbd_pkg;

	// field widths
	localparam int unsigned CAT_W     = 4;
	localparam int unsigned ATT_W     = 8;
	localparam int unsigned MS_W      = 32;
	localparam int unsigned MULT_W    = 16;
	localparam int unsigned NEXT_W    = 9;
	localparam int unsigned FRAC_W    = 8;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CFG_IDX_W  = 2;

	// fixed-point widths: accumulator below the ceiling, product, shifted product
	localparam int unsigned ACC_W  = MS_W + FRAC_W;
	localparam int unsigned PROD_W = ACC_W + MULT_W;
	localparam int unsigned NEXT_ACC_W = PROD_W - FRAC_W;

	// multiplier value 1.0 in unsigned Q8.8
	localparam logic [MULT_W-1:0] Q_ONE = 16'd256;

	// highest permanent error category
	localparam logic [CAT_W-1:0] CAT_PERMANENT_MAX = 4'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MS       = 2'd3;

	// register reset values
	localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPTS = 8'd3;
	localparam logic [MS_W-1:0]   RST_INITIAL_MS   = 32'd1000;
	localparam logic [MULT_W-1:0] RST_MULTIPLIER   = 16'd512;
	localparam logic [MS_W-1:0]   RST_MAX_MS       = 32'd60000;

	// decision outcome codes
	typedef enum logic [1:0] {
		OUTCOME_RETRY         = 2'd0,
		OUTCOME_NOT_RETRYABLE = 2'd1,
		OUTCOME_LIMIT         = 2'd2
	} outcome_t;

endpackage

### sv/retry_backoff_decision_core.sv
// retry_backoff_decision_core: capped exponential backoff decision per failure report
// depends on rbd_pkg; one shared 40x16 multiplier stepped by a small sequencer
//
// usage
//  - s_* channel takes one failure report per beat; m_* channel returns one
//    decision beat per report; cfg_* channel writes the four control registers
//    (always ready, write only while no report is in flight)
//  - a report is taken only while the sequencer is idle; permanent, non-recoverable
//    and limit-reached reports skip the multiply steps and go straight to done
//  - a granted retry with exponent e = max(0, attempts-1) runs k <= e multiply
//    steps, stopping early once the delay reaches the ceiling; each step is
//    multiply, shift-and-register, compare on the one shared multiplier
//  - the result sits in an output register; the next report is taken while it
//    waits, and a finished decision waits in the sequencer until that register
//    frees up, so a stalled receiver stops the block without losing a beat
//  - reset clears the sequencer and output valid and loads the register defaults
//    (limit 3, initial 1000 ms, multiplier 2.0, ceiling 60000 ms)
module retry_backoff_decision_core
	import rbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// report beat: [3:0] error_category, [4] recoverable, [12:5] attempts_so_far
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// decision beat: [0] should_retry, [32:1] delay_ms, [34:33] outcome,
	// [43:35] next_attempt
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MS_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [ATT_W-1:0]    max_attempts_q;
	logic [MS_W-1:0]     initial_ms_q;
	logic [MULT_W-1:0]   multiplier_q;
	logic [MS_W-1:0]     max_ms_q;

	logic [NEXT_ACC_W-1:0] acc_q;
	logic [PROD_W-1:0]     prod_q;
	logic [ATT_W-1:0]      exp_cnt_q;
	logic                  retry_q;
	outcome_t              outcome_q;
	logic [NEXT_W-1:0]     next_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// report fields
	logic [CAT_W-1:0] in_cat;
	logic             in_recov;
	logic [ATT_W-1:0] in_att;
	logic             in_accept;
	logic             permanent;
	logic             limit_hit;

	// arithmetic
	logic [MULT_W-1:0]     mult_eff;
	logic [NEXT_ACC_W-1:0] ceil_q8;
	logic                  at_ceiling;
	logic [MS_W-1:0]       delay_final;

	assign in_cat   = s_tdata[CAT_W-1:0];
	assign in_recov = s_tdata[CAT_W];
	assign in_att   = s_tdata[CAT_W+ATT_W:CAT_W+1];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign permanent = (in_cat <= CAT_PERMANENT_MAX) || !in_recov;
	assign limit_hit = (in_att >= max_attempts_q);

	// multiplier below 1.0 counts as 1.0
	assign mult_eff   = (multiplier_q < Q_ONE) ? Q_ONE : multiplier_q;
	assign ceil_q8    = {{(NEXT_ACC_W-ACC_W){1'b0}}, max_ms_q, {FRAC_W{1'b0}}};
	assign at_ceiling = (acc_q >= ceil_q8);
	assign delay_final = at_ceiling ? max_ms_q : acc_q[ACC_W-1:FRAC_W];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q <= RST_MAX_ATTEMPTS;
			initial_ms_q   <= RST_INITIAL_MS;
			multiplier_q   <= RST_MULTIPLIER;
			max_ms_q       <= RST_MAX_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[ATT_W-1:0];
				REG_INITIAL_MS:   initial_ms_q   <= cfg_data;
				REG_MULTIPLIER:   multiplier_q   <= cfg_data[MULT_W-1:0];
				REG_MAX_MS:       max_ms_q       <= cfg_data;
				default:          ;
			endcase
		end
	end

	// sequencer with registered decision outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			exp_cnt_q   <= '0;
			retry_q     <= 1'b0;
			outcome_q   <= OUTCOME_RETRY;
			next_q      <= '0;
		end else begin
			// output register drains on a taken beat unless a new decision refills it
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						acc_q     <= {{(NEXT_ACC_W-ACC_W){1'b0}}, initial_ms_q, {FRAC_W{1'b0}}};
						exp_cnt_q <= (in_att == '0) ? '0 : in_att - 1'b1;
						next_q    <= {1'b0, in_att} + 1'b1;
						if (permanent) begin
							retry_q   <= 1'b0;
							outcome_q <= OUTCOME_NOT_RETRYABLE;
							state_q   <= ST_DONE;
						end else if (limit_hit) begin
							retry_q   <= 1'b0;
							outcome_q <= OUTCOME_LIMIT;
							state_q   <= ST_DONE;
						end else begin
							retry_q   <= 1'b1;
							outcome_q <= OUTCOME_RETRY;
							state_q   <= ST_CHECK;
						end
					end
				end
				// stop at the ceiling or when the exponent is used up
				ST_CHECK: begin
					if (at_ceiling || exp_cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				// shared multiplier: accumulator is below the ceiling here
				ST_MUL: begin
					prod_q  <= acc_q[ACC_W-1:0] * mult_eff;
					state_q <= ST_UPDATE;
				end
				// drop 8 fraction bits, count the step
				ST_UPDATE: begin
					acc_q     <= prod_q[PROD_W-1:FRAC_W];
					exp_cnt_q <= exp_cnt_q - 1'b1;
					state_q   <= ST_CHECK;
				end
				// hand over once the output register is free
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						if (retry_q) begin
							out_data_q <= {{(OUT_DATA_W-NEXT_W-2-MS_W-1){1'b0}},
								next_q, outcome_q, delay_final, 1'b1};
						end else begin
							out_data_q <= {{(OUT_DATA_W-NEXT_W-2-MS_W-1){1'b0}},
								{NEXT_W{1'b0}}, outcome_q, {MS_W{1'b0}}, 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/rbd_checker.sv
// rbd_checker: port-level assertions on retry_backoff_decision_core
// depends on rbd_pkg; bound to the top level at the end of this file
module rbd_checker
	import rbd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled decision beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("decision beat changed while stalled");

	// a granted retry always carries the retry outcome and a nonzero attempt number
	a_retry_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[34:33] == OUTCOME_RETRY
			&& m_tdata[43:35] != '0)
		else $error("granted retry with wrong outcome or attempt number");

	// a refused retry has zero delay and attempt number and a refusal outcome
	a_refusal_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0 && m_tdata[43:35] == '0
			&& (m_tdata[34:33] == OUTCOME_NOT_RETRYABLE
				|| m_tdata[34:33] == OUTCOME_LIMIT))
		else $error("refused retry with nonzero fields or wrong outcome");

	// one report at a time: busy right after a report beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second report taken while busy");

endmodule

bind retry_backoff_decision_core rbd_checker u_rbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
